@@ rtl/core/stshelf_pkg.sv @@
// Shared types, constants and coefficient decode for the stereo shelf equalizer.
`default_nettype none

package stshelf_pkg;

    // Coefficient word: 14-bit signed mantissa, 13 fractional bits, 2-bit shift code
    localparam int COEF_WORD_W = 16;
    localparam int MANT_W      = 14;
    localparam int COEF_W      = 18;
    localparam int COEF_FRAC   = 13;
    localparam int NUM_COEFS   = 6;
    localparam int COEF_IDX_W  = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_INPUT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PREV_IN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FEEDBACK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_INPUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PREV_IN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FEEDBACK = 3'd6;

    // Reset value of the two direct-path coefficients: +1.0
    localparam logic [COEF_WORD_W-1:0] COEF_UNITY = 16'h5000;

    // Multiply term within one band
    typedef enum logic [1:0] {
        TERM_INPUT    = 2'd0,
        TERM_PREV_IN  = 2'd1,
        TERM_FEEDBACK = 2'd2
    } term_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // Expand a raw coefficient word into m << e with 13 fractional bits
    function automatic logic signed [COEF_W-1:0] decode_coef(
        input logic [COEF_WORD_W-1:0] word
    );
        logic signed [COEF_W-1:0] mant;
        mant = COEF_W'($signed(word[MANT_W-1:0]));
        case (word[COEF_WORD_W-1:MANT_W])
            2'd0:    decode_coef = mant;
            2'd1:    decode_coef = mant <<< 1;
            2'd2:    decode_coef = mant <<< 2;
            2'd3:    decode_coef = mant <<< 4;
            default: decode_coef = mant;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/stshelf_if.sv @@
// Valid/ready channel interfaces for stereo frames in and equalized frames out.
`default_nettype none

interface stshelf_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last_frame;

    modport source (output valid, left_sample, right_sample, last_frame, input ready);
    modport sink   (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

interface stshelf_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_result;
    logic signed [SAMPLE_BITS-1:0] right_result;
    logic                          last_result;

    modport source (output valid, left_result, right_result, last_result, input ready);
    modport sink   (input valid, left_result, right_result, last_result, output ready);
endinterface

`default_nettype wire

@@ rtl/core/stereo_two_band_shelf_eq_unit.sv @@
// Stereo two-band first-order shelving equalizer built around one shared multiplier.
//
// Usage:
//   frame  : sink channel, one beat carries a left and a right sample (signed Q1.23
//            at the default width) and a last_frame mark.
//   result : source channel, one beat per frame with the equalized samples and
//            last_result copied from last_frame.
//   cfg_we / cfg_index / cfg_data : write-only register port, written while idle.
// Each channel passes a low shelf and then a high shelf, y = c0*x + c1*x1 + c2*y1.
// One 18 x SAMPLE_BITS multiplier computes all twelve products, one per cycle while
// in the multiply state: a band multiplies the input, previous-input and feedback
// terms and then sums and saturates in the finish state, and after the last band
// the done state loads the output register. frame.ready is low after the frame beat
// until that load, and the next frame can be taken while the result beat is valid.
// With enable at 0 the frame goes straight to the done state and the history holds.
// A finished frame waits in the output register while the receiver stalls; the
// block accepts one more frame meanwhile and holds its result until the register
// drains.
// Reset clears the history, enables filtering and sets both direct coefficients
// to +1.0 and the others to zero.
`default_nettype none

module stereo_two_band_shelf_eq_unit #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    stshelf_in_if.sink                                 frame,
    stshelf_out_if.source                              result,
    input  wire logic                                  cfg_we,
    input  wire logic [stshelf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [stshelf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // History exists only for the channels of the frame that CHANNELS covers
    localparam int HIST_CH = (CHANNELS < 2) ? 1 : 2;
    localparam int PROD_W  = SAMPLE_BITS + stshelf_pkg::COEF_W;
    localparam int ACC_W   = SAMPLE_BITS + 7;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    stshelf_pkg::state_t state_reg, state_next;
    stshelf_pkg::term_t  term_reg, term_next;
    logic                band_reg, band_next;
    logic                ch_reg, ch_next;

    logic                                  enable_reg;
    logic [stshelf_pkg::COEF_WORD_W-1:0]   coef_reg [0:stshelf_pkg::NUM_COEFS-1];

    sample_t low_px_reg  [0:HIST_CH-1];
    sample_t low_py_reg  [0:HIST_CH-1];
    sample_t high_px_reg [0:HIST_CH-1];
    sample_t high_py_reg [0:HIST_CH-1];

    sample_t                   res_reg [0:1];
    logic                      last_reg;
    sample_t                   mid_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    logic                      out_valid_reg;
    sample_t                   out_left_reg, out_right_reg;
    logic                      out_last_reg;

    logic                      hidx;
    logic [stshelf_pkg::COEF_IDX_W-1:0] coef_idx;
    sample_t                   x_sel, op_sel;
    logic signed [PROD_W-1:0]  op_ext, coef_ext;
    logic signed [ACC_W-1:0]   prod_sh, sum;
    sample_t                   y_sat;
    logic                      take_frame, load_out;

    assign hidx       = (HIST_CH == 1) ? 1'b0 : ch_reg;
    assign take_frame = frame.valid && frame.ready;
    assign load_out   = (state_reg == stshelf_pkg::ST_DONE) && (!out_valid_reg || result.ready);

    assign frame.ready         = (state_reg == stshelf_pkg::ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.left_result  = out_left_reg;
    assign result.right_result = out_right_reg;
    assign result.last_result  = out_last_reg;

    // Operand selection for the shared multiplier
    always_comb
    begin
        x_sel    = band_reg ? mid_reg : res_reg[ch_reg];
        coef_idx = band_reg ? stshelf_pkg::COEF_IDX_W'(3 + int'(term_reg))
                            : stshelf_pkg::COEF_IDX_W'(term_reg);
        case (term_reg)
            stshelf_pkg::TERM_INPUT:    op_sel = x_sel;
            stshelf_pkg::TERM_PREV_IN:  op_sel = band_reg ? high_px_reg[hidx] : low_px_reg[hidx];
            stshelf_pkg::TERM_FEEDBACK: op_sel = band_reg ? high_py_reg[hidx] : low_py_reg[hidx];
            default:                    op_sel = x_sel;
        endcase
        op_ext   = PROD_W'(op_sel);
        coef_ext = PROD_W'(stshelf_pkg::decode_coef(coef_reg[coef_idx]));
    end

    // Truncate toward minus infinity, then sum and saturate
    always_comb
    begin
        prod_sh = ACC_W'(prod_reg >>> stshelf_pkg::COEF_FRAC);
        sum     = acc_reg + prod_sh;
        if (sum > SAT_HI)
            y_sat = SAMPLE_BITS'(SAT_HI);
        else if (sum < SAT_LO)
            y_sat = SAMPLE_BITS'(SAT_LO);
        else
            y_sat = SAMPLE_BITS'(sum);
        acc_next = (term_reg == stshelf_pkg::TERM_INPUT) ? '0 : sum;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        band_next  = band_reg;
        ch_next    = ch_reg;
        unique case (state_reg)
            stshelf_pkg::ST_IDLE:
            begin
                term_next = stshelf_pkg::TERM_INPUT;
                band_next = 1'b0;
                ch_next   = 1'b0;
                if (take_frame)
                    state_next = enable_reg ? stshelf_pkg::ST_MUL : stshelf_pkg::ST_DONE;
            end
            stshelf_pkg::ST_MUL:
            begin
                unique case (term_reg)
                    stshelf_pkg::TERM_INPUT:    term_next = stshelf_pkg::TERM_PREV_IN;
                    stshelf_pkg::TERM_PREV_IN:  term_next = stshelf_pkg::TERM_FEEDBACK;
                    default:
                    begin
                        term_next  = stshelf_pkg::TERM_INPUT;
                        state_next = stshelf_pkg::ST_FIN;
                    end
                endcase
            end
            stshelf_pkg::ST_FIN:
            begin
                if (!band_reg)
                begin
                    band_next  = 1'b1;
                    state_next = stshelf_pkg::ST_MUL;
                end
                else if (int'(ch_reg) + 1 < HIST_CH)
                begin
                    band_next  = 1'b0;
                    ch_next    = 1'b1;
                    state_next = stshelf_pkg::ST_MUL;
                end
                else
                    state_next = stshelf_pkg::ST_DONE;
            end
            stshelf_pkg::ST_DONE:
            begin
                if (load_out)
                    state_next = stshelf_pkg::ST_IDLE;
            end
            default:
                state_next = stshelf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stshelf_pkg::ST_IDLE;
            term_reg  <= stshelf_pkg::TERM_INPUT;
            band_reg  <= 1'b0;
            ch_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            band_reg  <= band_next;
            ch_reg    <= ch_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            for (int i = 0; i < stshelf_pkg::NUM_COEFS; i++)
                coef_reg[i] <= '0;
            coef_reg[0] <= stshelf_pkg::COEF_UNITY;
            coef_reg[3] <= stshelf_pkg::COEF_UNITY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stshelf_pkg::REG_ENABLE:        enable_reg  <= cfg_data[0];
                stshelf_pkg::REG_LOW_INPUT:     coef_reg[0] <= cfg_data;
                stshelf_pkg::REG_LOW_PREV_IN:   coef_reg[1] <= cfg_data;
                stshelf_pkg::REG_LOW_FEEDBACK:  coef_reg[2] <= cfg_data;
                stshelf_pkg::REG_HIGH_INPUT:    coef_reg[3] <= cfg_data;
                stshelf_pkg::REG_HIGH_PREV_IN:  coef_reg[4] <= cfg_data;
                stshelf_pkg::REG_HIGH_FEEDBACK: coef_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Filter history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_CH; i++)
            begin
                low_px_reg[i]  <= '0;
                low_py_reg[i]  <= '0;
                high_px_reg[i] <= '0;
                high_py_reg[i] <= '0;
            end
        end
        else if (state_reg == stshelf_pkg::ST_FIN)
        begin
            if (band_reg)
            begin
                high_px_reg[hidx] <= mid_reg;
                high_py_reg[hidx] <= y_sat;
            end
            else
            begin
                low_px_reg[hidx] <= res_reg[ch_reg];
                low_py_reg[hidx] <= y_sat;
            end
        end
    end

    // Datapath: frame capture, multiply, accumulate
    always_ff @(posedge clk)
    begin
        if (take_frame)
        begin
            res_reg[0] <= frame.left_sample;
            res_reg[1] <= frame.right_sample;
            last_reg   <= frame.last_frame;
        end
        if (state_reg == stshelf_pkg::ST_MUL)
        begin
            prod_reg <= op_ext * coef_ext;
            acc_reg  <= acc_next;
        end
        if (state_reg == stshelf_pkg::ST_FIN)
        begin
            if (band_reg)
                res_reg[ch_reg] <= y_sat;
            else
                mid_reg <= y_sat;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_left_reg  <= res_reg[0];
            out_right_reg <= res_reg[1];
            out_last_reg  <= last_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/stshelf_chk.sv @@
// Port-level checks for the shelf equalizer, bound to the top level.
`default_nettype none

module stshelf_chk #(
    parameter int SAMPLE_BITS = 24
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [SAMPLE_BITS-1:0] out_left,
    input wire logic [SAMPLE_BITS-1:0] out_right,
    input wire logic                   out_last
);

    // One frame in work at a time: ready drops right after a frame beat
    a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("frame accepted while a frame was in work");

    // A result appears only out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result beat without frame work");

    // A stalled result beat holds its payload
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_left) &&
        $stable(out_right) && $stable(out_last))
        else $error("stalled result beat changed");

    // Reset empties the output register and opens the input by the next edge
    a_reset_state: assert property (@(posedge clk)
        !rst_n |=> !out_valid && in_ready)
        else $error("reset did not clear the channels");

endmodule

bind stereo_two_band_shelf_eq_unit stshelf_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_stshelf_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_left  (result.left_result),
    .out_right (result.right_result),
    .out_last  (result.last_result)
);

`default_nettype wire
